>>> sv/bresenham_line_stepper_unit_assert.svh
// Assertion macros used by the line stepper back end.
`ifndef BRESENHAM_LINE_STEPPER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/blsu_pkg.sv
// Shared types and constants of the line stepper.
`default_nettype none

package blsu_pkg;

    localparam int COLOR_BITS     = 32;
    localparam int BLEND_BITS     = 4;
    localparam int CFG_INDEX_BITS = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [COLOR_BITS-1:0] PIXEL_COLOR_RESET = '1;
    localparam logic [BLEND_BITS-1:0] BLEND_SELECT_RESET = '0;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_PIXEL_COLOR  = cfg_index_t'(0);
    localparam cfg_index_t CFG_BLEND_SELECT = cfg_index_t'(1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_kind_t;

endpackage

`default_nettype wire

>>> sv/blsu_queue.sv
// Small register queue between the front and the back of the stepper.
`default_nettype none

module blsu_queue import blsu_pkg::*; #(
    parameter int DATA_BITS = 63,
    parameter int DEPTH     = 2     // power of two
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  wr_en,
    input  wire  [DATA_BITS-1:0] wr_data,
    output logic                 full,
    input  wire                  rd_en,
    output logic                 rd_valid,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/blsu_front.sv
// Front end: accepts items, sorts out axis, direction and endpoint order of loads.
`default_nettype none

module blsu_front import blsu_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  cmd_kind_t                     kind,
    input  wire  signed [COORD_BITS-1:0]  start_x,
    input  wire  signed [COORD_BITS-1:0]  start_y,
    input  wire  signed [COORD_BITS-1:0]  end_x,
    input  wire  signed [COORD_BITS-1:0]  end_y,
    input  wire                           q_full,
    output logic                          q_wr,
    // {kind, y_major, minor_neg, abs_major, abs_minor, major_end, first_y, first_x}
    output logic [5*COORD_BITS+2:0]       q_data
);

    localparam int N = COORD_BITS;

    logic signed [N:0]   dx, dy, dmin;
    logic        [N:0]   ndx, ndy;
    logic        [N-1:0] adx, ady, amaj, amin;
    logic                y_major, swap, minor_neg;
    logic signed [N-1:0] first_x, first_y, major_end;

    assign s_tready = !q_full;
    assign q_wr     = s_tvalid && !q_full;

    always_comb begin
        dx  = $signed({end_x[N-1], end_x}) - $signed({start_x[N-1], start_x});
        dy  = $signed({end_y[N-1], end_y}) - $signed({start_y[N-1], start_y});
        ndx = -dx;
        ndy = -dy;
        adx = dx[N] ? ndx[N-1:0] : dx[N-1:0];
        ady = dy[N] ? ndy[N-1:0] : dy[N-1:0];

        // ties, including single points, go y-major
        y_major = !(ady < adx);
        swap    = y_major ? (start_y > end_y) : (start_x > end_x);

        first_x = swap ? end_x : start_x;
        first_y = swap ? end_y : start_y;
        if (y_major) begin
            major_end = swap ? start_y : end_y;
            amaj      = ady;
            amin      = adx;
            dmin      = dx;
        end else begin
            major_end = swap ? start_x : end_x;
            amaj      = adx;
            amin      = ady;
            dmin      = dy;
        end
        // swapping the endpoints flips the sign of the minor delta
        minor_neg = (dmin != '0) && (dmin[N] ^ swap);

        q_data = {kind, y_major, minor_neg, amaj, amin, major_end, first_y, first_x};
    end

endmodule

`default_nettype wire

>>> sv/blsu_back.sv
// Back end: walks the loaded line one pixel per step and holds the result register.
`default_nettype none

`include "bresenham_line_stepper_unit_assert.svh"

module blsu_back import blsu_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    input  cfg_index_t                   cfg_index,
    input  wire  [COLOR_BITS-1:0]        cfg_data,
    input  wire                          q_valid,
    input  wire  [5*COORD_BITS+2:0]      q_data,
    output logic                         q_rd,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic [COLOR_BITS-1:0]        pix_color,
    output logic [BLEND_BITS-1:0]        pix_blend,
    output logic                         last_pixel
);

    localparam int N  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    // unpacked queue entry
    cmd_kind_t           e_kind;
    logic                e_kind_bit;
    logic                e_y_major, e_minor_neg;
    logic        [N-1:0] e_amaj, e_amin;
    logic signed [N-1:0] e_major_end, e_first_y, e_first_x;

    assign {e_kind_bit, e_y_major, e_minor_neg, e_amaj, e_amin,
            e_major_end, e_first_y, e_first_x} = q_data;
    assign e_kind = cmd_kind_t'(e_kind_bit);

    logic [COLOR_BITS-1:0] pixel_color_reg;
    logic [BLEND_BITS-1:0] blend_select_reg;

    logic signed [N-1:0]  cur_x_reg, cur_x_next;
    logic signed [N-1:0]  cur_y_reg, cur_y_next;
    logic signed [N-1:0]  major_end_reg, major_end_next;
    logic signed [EW-1:0] error_reg, error_next;
    logic        [N:0]    twice_minor_reg, twice_minor_next;
    logic        [N:0]    twice_major_reg, twice_major_next;
    logic                 minor_neg_reg, minor_neg_next;
    logic                 y_major_reg, y_major_next;
    logic                 active_reg, active_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [N-1:0]  pix_x_reg, pix_y_reg;
    logic [COLOR_BITS-1:0] pix_color_reg;
    logic [BLEND_BITS-1:0] pix_blend_reg;
    logic                 last_reg;

    logic                 slot_free, pop, emit, at_last;
    logic signed [N-1:0]  maj_cur, min_cur, maj_inc, min_step;
    logic signed [EW-1:0] err_sub;

    assign slot_free = !out_valid_reg || out_ready;
    // a load, or a step with no line, never waits for the result slot
    assign pop  = q_valid && ((e_kind == CMD_LOAD) || !active_reg || slot_free);
    assign emit = pop && (e_kind == CMD_STEP) && active_reg;
    assign q_rd = pop;

    always_comb begin
        maj_cur  = y_major_reg ? cur_y_reg : cur_x_reg;
        min_cur  = y_major_reg ? cur_x_reg : cur_y_reg;
        at_last  = (maj_cur == major_end_reg);
        maj_inc  = maj_cur + N'(1);
        min_step = (error_reg > 0) ? (minor_neg_reg ? min_cur - N'(1) : min_cur + N'(1))
                                   : min_cur;
        err_sub  = (error_reg > 0) ? $signed({2'b00, twice_major_reg}) : '0;

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        error_next       = error_reg;
        twice_minor_next = twice_minor_reg;
        twice_major_next = twice_major_reg;
        minor_neg_next   = minor_neg_reg;
        y_major_next     = y_major_reg;
        active_next      = active_reg;

        if (pop && (e_kind == CMD_LOAD)) begin
            cur_x_next       = e_first_x;
            cur_y_next       = e_first_y;
            major_end_next   = e_major_end;
            twice_minor_next = {e_amin, 1'b0};
            twice_major_next = {e_amaj, 1'b0};
            minor_neg_next   = e_minor_neg;
            y_major_next     = e_y_major;
            error_next       = $signed({2'b00, e_amin, 1'b0}) - $signed({3'b000, e_amaj});
            active_next      = 1'b1;
        end else if (emit) begin
            if (at_last) begin
                active_next = 1'b0;
            end else begin
                error_next = error_reg + $signed({2'b00, twice_minor_reg}) - err_sub;
                if (y_major_reg) begin
                    cur_y_next = maj_inc;
                    cur_x_next = min_step;
                end else begin
                    cur_x_next = maj_inc;
                    cur_y_next = min_step;
                end
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_color_reg  <= PIXEL_COLOR_RESET;
            blend_select_reg <= BLEND_SELECT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PIXEL_COLOR:  pixel_color_reg  <= cfg_data;
                CFG_BLEND_SELECT: blend_select_reg <= cfg_data[BLEND_BITS-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            error_reg       <= '0;
            twice_minor_reg <= '0;
            twice_major_reg <= '0;
            minor_neg_reg   <= 1'b0;
            y_major_reg     <= 1'b0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            error_reg       <= error_next;
            twice_minor_reg <= twice_minor_next;
            twice_major_reg <= twice_major_next;
            minor_neg_reg   <= minor_neg_next;
            y_major_reg     <= y_major_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pix_x_reg     <= cur_x_reg;
            pix_y_reg     <= cur_y_reg;
            pix_color_reg <= pixel_color_reg;
            pix_blend_reg <= blend_select_reg;
            last_reg      <= at_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pix_x      = pix_x_reg;
    assign pix_y      = pix_y_reg;
    assign pix_color  = pix_color_reg;
    assign pix_blend  = pix_blend_reg;
    assign last_pixel = last_reg;

    `BLSU_ASSERT_NEXT(a_load_activates, aclk, aresetn, pop && (e_kind == CMD_LOAD),
                      active_reg, "line not active after load")
    `BLSU_ASSERT_NEXT(a_last_ends_line, aclk, aresetn, emit && at_last,
                      !active_reg, "line still active after last pixel")
    `BLSU_ASSERT_NEXT(a_idle_step_silent, aclk, aresetn, pop && !active_reg && !out_valid_reg,
                      !out_valid_reg, "result appeared without an active line")
    `BLSU_ASSERT_NOW(a_emit_has_slot, aclk, aresetn, emit, slot_free, "result register overwritten")

endmodule

`default_nettype wire

>>> sv/bresenham_line_stepper_unit.sv
// Line stepper top level: load a line's endpoints, then get one pixel per step item.
//
// Input channel s_*: s_tuser is the mode (0 loads a line, 1 asks for the next pixel);
// s_tdata carries start_x, start_y, end_x, end_y. A load replaces any unfinished line
// and gives no result; a step with no line in progress gives no result either.
// Result channel m_*: m_tdata carries pix_x, pix_y, pix_color, pix_blend; m_tlast
// marks the final pixel of the line.
// Configuration: cfg_index 0 writes the pixel colour, 1 the blend select; other
// indexes are ignored. cfg_ready is always high; write only while the block is idle.
// Path: a step item is written into the command queue, then the walker pops it and
// loads its pixel into the result register, which drives m_tvalid.
// Throughput: one item per cycle unless a step waits on a held result register; each
// step is a single add, compare and increment in the walker, which sets the rate.
// Stall: the result register holds while m_tready is low, the two-entry command
// queue keeps taking items and s_tready drops once it is full.
// Reset (aresetn low, synchronous): queue empty, no line active, colour all ones,
// blend select zero.
`default_nettype none

module bresenham_line_stepper_unit import blsu_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,

    input  wire                     s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, end_x, end_y, zero pad
    input  wire  [((4*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // mode
    input  wire                     s_tuser,

    output logic                    m_tvalid,
    input  wire                     m_tready,
    // pix_x, pix_y, pix_color, pix_blend, zero pad
    output logic [((2*COORD_BITS+COLOR_BITS+BLEND_BITS+7)/8)*8-1:0] m_tdata,
    output logic                    m_tlast,

    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  cfg_index_t              cfg_index,
    input  wire  [COLOR_BITS-1:0]   cfg_data
);

    localparam int N          = COORD_BITS;
    localparam int ENTRY_BITS = 5*COORD_BITS + 3;
    localparam int M_BITS     = ((2*COORD_BITS+COLOR_BITS+BLEND_BITS+7)/8)*8;
    localparam int M_USED     = 2*COORD_BITS + COLOR_BITS + BLEND_BITS;

    logic                  q_full, q_wr, q_rd, q_valid;
    logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;

    logic signed [N-1:0]   pix_x, pix_y;
    logic [COLOR_BITS-1:0] pix_color;
    logic [BLEND_BITS-1:0] pix_blend;

    assign cfg_ready = 1'b1;

    blsu_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (cmd_kind_t'(s_tuser)),
        .start_x  ($signed(s_tdata[N-1:0])),
        .start_y  ($signed(s_tdata[2*N-1:N])),
        .end_x    ($signed(s_tdata[3*N-1:2*N])),
        .end_y    ($signed(s_tdata[4*N-1:3*N])),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (q_wr_data)
    );

    blsu_queue #(
        .DATA_BITS(ENTRY_BITS),
        .DEPTH    (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    blsu_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_data     (q_rd_data),
        .q_rd       (q_rd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pix_color  (pix_color),
        .pix_blend  (pix_blend),
        .last_pixel (m_tlast)
    );

    assign m_tdata = M_BITS'({pix_blend, pix_color, pix_y, pix_x}) & {{(M_BITS-M_USED){1'b0}},
                     {M_USED{1'b1}}};

endmodule

`default_nettype wire
